FILE: rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // pending operator
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_ADD,
        CLS_MUL,
        CLS_OPEN,
        CLS_CLOSE
    } t_cls;

    // classified character as it sits in the queue
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_item;

    // one saved nesting level
    typedef struct packed {
        logic [WORD_W-1:0] product;
        logic [WORD_W-1:0] term;
        logic              op;
    } t_frame;

    typedef enum logic [2:0] {
        S_FETCH,
        S_EXEC,
        S_FOLD,
        S_CLOSE1,
        S_CLOSE2,
        S_FINAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] result;
    } t_mul_rsp;

endpackage

FILE: rtl/iee_if.sv
// ----------------------------------------------------------------------------
// iee_if
// Valid/ready channels of the evaluator: characters in, results out, config.
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iee_out_if import iee_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic                     malformed;

    modport source (output valid, output value, output malformed, input ready);
    modport sink   (input valid, input value, input malformed, output ready);
endinterface

interface iee_cfg_if;
    logic valid;
    logic ready;
    logic precedence_mode;

    modport source (output valid, output precedence_mode, input ready);
    modport sink   (input valid, input precedence_mode, output ready);
endinterface

FILE: rtl/iee_front.sv
// ----------------------------------------------------------------------------
// iee_front
// Accepts characters and classifies them into queue items.
// ----------------------------------------------------------------------------
module iee_front import iee_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_push,
    output t_item      o_item,
    input  logic       i_full
);

    function automatic t_item classify(input logic [7:0] c, input logic last);
        t_item it;
        it.digit = 4'd0;
        it.last  = last;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            it.cls   = CLS_DIGIT;
            it.digit = 4'(c - CH_ZERO);
        end else if (c == CH_PLUS) begin
            it.cls = CLS_ADD;
        end else if (c == CH_STAR) begin
            it.cls = CLS_MUL;
        end else if (c == CH_OPEN) begin
            it.cls = CLS_OPEN;
        end else if (c == CH_CLOSE) begin
            it.cls = CLS_CLOSE;
        end else begin
            it.cls = CLS_NONE;
        end
        return it;
    endfunction

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_take;
    logic  w_push_ok;

    assign w_push_ok = r_valid && !i_full;
    assign o_ready   = !r_valid || !i_full;
    assign w_take    = i_valid && o_ready;
    assign o_push    = w_push_ok;
    assign o_item    = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (w_push_ok) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= classify(i_char_code, i_last_char);
        end
    end

endmodule

FILE: rtl/iee_queue.sv
// ----------------------------------------------------------------------------
// iee_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module iee_queue import iee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_count;
    logic [Q_AW-1:0]  n_wr;
    logic [Q_AW-1:0]  n_rd;
    logic [Q_CW-1:0]  n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr    = w_wr ? Q_AW'(r_wr + 1'b1) : r_wr;
        n_rd    = w_rd ? Q_AW'(r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (w_rd && !w_wr) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/iee_mul.sv
// ----------------------------------------------------------------------------
// iee_mul
// 64x64 multiplier, low word only, from three 32x32 partial products.
// ----------------------------------------------------------------------------
module iee_mul import iee_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_busy;
    logic [1:0]        r_cnt;
    logic [WORD_W-1:0] r_p;
    logic              r_pv;
    logic [1:0]        r_pk;
    logic [WORD_W-1:0] r_acc;
    logic              r_done;

    logic              n_busy;
    logic [1:0]        n_cnt;
    logic              n_pv;
    logic              n_done;
    logic [WORD_W-1:0] n_acc;
    logic [HALF_W-1:0] w_x;
    logic [HALF_W-1:0] w_y;
    logic [WORD_W-1:0] w_prod;

    // partial product schedule: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_cnt)
            2'd0: begin
                w_x = r_a[HALF_W-1:0];
                w_y = r_b[HALF_W-1:0];
            end
            2'd1: begin
                w_x = r_a[HALF_W-1:0];
                w_y = r_b[WORD_W-1:HALF_W];
            end
            2'd2: begin
                w_x = r_a[WORD_W-1:HALF_W];
                w_y = r_b[HALF_W-1:0];
            end
            default: begin
                w_x = '0;
                w_y = '0;
            end
        endcase
    end

    assign w_prod = WORD_W'(w_x) * WORD_W'(w_y);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_pv   = 1'b0;
        n_done = 1'b0;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 2'd0;
        end else if (r_busy) begin
            if (r_cnt != 2'd3) begin
                n_pv  = 1'b1;
                n_cnt = 2'(r_cnt + 1'b1);
            end
            if (r_pv) begin
                if (r_pk == 2'd0) begin
                    n_acc = r_p;
                end else begin
                    n_acc = r_acc + {r_p[HALF_W-1:0], {HALF_W{1'b0}}};
                end
                if (r_pk == 2'd2) begin
                    n_done = 1'b1;
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_pv   <= n_pv;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_p   <= w_prod;
        r_pk  <= r_cnt;
        r_acc <= n_acc;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

FILE: rtl/iee_back.sv
// ----------------------------------------------------------------------------
// iee_back
// Executes queued items: level state, nesting stack and result register.
// ----------------------------------------------------------------------------
module iee_back import iee_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_mode,
    input  logic                       i_q_valid,
    input  t_item                      i_q_item,
    output logic                       o_q_pop,
    output t_mul_req                   o_mul_req,
    input  t_mul_rsp                   i_mul_rsp,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [WORD_W-1:0]          o_out_value,
    output logic                       o_out_malformed,
    output t_state                     o_state,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_level
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [LW-1:0] FULL_LVL = LW'(STACK_DEPTH);

    t_state            r_state;
    t_state            n_state;
    t_item             r_item;
    t_item             n_item;
    logic [WORD_W-1:0] r_product;
    logic [WORD_W-1:0] n_product;
    logic [WORD_W-1:0] r_term;
    logic [WORD_W-1:0] n_term;
    logic              r_op;
    logic              n_op;
    logic [LW-1:0]     r_level;
    logic [LW-1:0]     n_level;
    logic              r_err;
    logic              n_err;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_out_value;
    logic              r_out_mal;
    logic              w_load_out;

    // nesting stack
    t_frame            mem [STACK_DEPTH];
    t_frame            r_rd;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [LW-1:0]     w_lvl_dec;
    logic [AW-1:0]     w_rd_addr;
    logic [AW-1:0]     w_wr_addr;

    logic              w_fold;
    logic              w_open_ok;
    logic              w_close_ok;
    logic              w_char_end;
    logic              w_out_free;

    assign w_lvl_dec  = LW'(r_level - 1'b1);
    assign w_rd_addr  = w_lvl_dec[AW-1:0];
    assign w_wr_addr  = r_level[AW-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_fold     = (r_item.cls == CLS_MUL) && i_mode;
    assign w_open_ok  = (r_item.cls == CLS_OPEN) && (r_level != FULL_LVL);
    assign w_close_ok = (r_item.cls == CLS_CLOSE) && (r_level != '0);

    // character fully applied to the top level this cycle
    always_comb begin
        w_char_end = 1'b0;
        case (r_state)
            S_EXEC:   w_char_end = !w_fold && !w_close_ok;
            S_FOLD:   w_char_end = i_mul_rsp.done;
            S_CLOSE1: w_char_end = i_mul_rsp.done && (r_rd.op == OP_ADD);
            S_CLOSE2: w_char_end = i_mul_rsp.done;
            default:  w_char_end = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FETCH: begin
                if (i_q_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fold) begin
                    n_state = S_FOLD;
                end else if (w_close_ok) begin
                    n_state = S_CLOSE1;
                end
            end
            S_CLOSE1: begin
                if (i_mul_rsp.done && r_rd.op == OP_MUL) begin
                    n_state = S_CLOSE2;
                end
            end
            S_FINAL: begin
                if (i_mul_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_FETCH;
                end
            end
            default: n_state = r_state;
        endcase
        if (w_char_end) begin
            n_state = r_item.last ? S_FINAL : S_FETCH;
        end
    end

    // datapath and outputs
    always_comb begin
        n_item      = r_item;
        n_product   = r_product;
        n_term      = r_term;
        n_op        = r_op;
        n_level     = r_level;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        w_load_out  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        o_q_pop     = 1'b0;
        o_mul_req   = '0;
        case (r_state)
            S_FETCH: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_item = i_q_item;
                end
            end
            S_EXEC: begin
                case (r_item.cls)
                    CLS_DIGIT: begin
                        if (r_op == OP_MUL) begin
                            n_term = r_term * WORD_W'(r_item.digit);
                        end else begin
                            n_term = r_term + WORD_W'(r_item.digit);
                        end
                    end
                    CLS_ADD: n_op = OP_ADD;
                    CLS_MUL: begin
                        if (i_mode) begin
                            o_mul_req.start = 1'b1;
                            o_mul_req.a     = r_product;
                            o_mul_req.b     = r_term;
                        end else begin
                            n_op = OP_MUL;
                        end
                    end
                    CLS_OPEN: begin
                        if (w_open_ok) begin
                            w_mem_we  = 1'b1;
                            n_level   = LW'(r_level + 1'b1);
                            n_product = WORD_W'(1);
                            n_term    = '0;
                            n_op      = OP_ADD;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    CLS_CLOSE: begin
                        if (w_close_ok) begin
                            w_mem_re        = 1'b1;
                            o_mul_req.start = 1'b1;
                            o_mul_req.a     = r_product;
                            o_mul_req.b     = r_term;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_FOLD: begin
                if (i_mul_rsp.done) begin
                    n_product = i_mul_rsp.result;
                    n_term    = '0;
                    n_op      = OP_ADD;
                end
            end
            S_CLOSE1: begin
                // inner value ready, outer level popped
                if (i_mul_rsp.done) begin
                    n_product = r_rd.product;
                    n_op      = r_rd.op;
                    n_level   = w_lvl_dec;
                    if (r_rd.op == OP_MUL) begin
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = r_rd.term;
                        o_mul_req.b     = i_mul_rsp.result;
                    end else begin
                        n_term = r_rd.term + i_mul_rsp.result;
                    end
                end
            end
            S_CLOSE2: begin
                if (i_mul_rsp.done) begin
                    n_term = i_mul_rsp.result;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    w_load_out  = 1'b1;
                    n_product   = WORD_W'(1);
                    n_term      = '0;
                    n_op        = OP_ADD;
                    n_level     = '0;
                    n_err       = 1'b0;
                end
            end
            default: ;
        endcase
        // last character: product of the finished level
        if (w_char_end && r_item.last) begin
            o_mul_req.start = 1'b1;
            o_mul_req.a     = n_product;
            o_mul_req.b     = n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_product   <= WORD_W'(1);
            r_term      <= '0;
            r_op        <= OP_ADD;
            r_level     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_product   <= n_product;
            r_term      <= n_term;
            r_op        <= n_op;
            r_level     <= n_level;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (w_load_out) begin
            r_out_value <= i_mul_rsp.result;
            r_out_mal   <= r_err || (r_level != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_wr_addr] <= t_frame'{product: r_product, term: r_term, op: r_op};
        end
        if (w_mem_re) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_value     = r_out_value;
    assign o_out_malformed = r_out_mal;
    assign o_state         = r_state;
    assign o_level         = r_level;

endmodule

FILE: rtl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an infix expression of digits, '+', '*' and parentheses, one
// character word at a time, and returns its 64-bit value and a malformed flag.
// ----------------------------------------------------------------------------
//  channel  dir  words carried                 handshake
//  i_in     in   char_code[7:0], last_char     valid/ready
//  o_out    out  value[63:0] signed, malformed valid/ready
//  i_cfg    in   precedence_mode               valid/ready, always ready
//
//  Steps: digit, '+', '(' and ignored characters take a fetch and an exec step;
//  '*' in mode 1 and ')' add one multiply, ')' two when the outer operator
//  is multiply; a last character adds one more multiply plus an emit step.
//  Each multiply runs on the shared multiplier (three 32x32 partial products).
//  Reset: synchronous, active low; the nesting stack itself is not cleared.
//  Stalls: front register plus a four-word queue keep taking characters while
//  the back end waits on the multiplier or on a result not yet taken.
// ----------------------------------------------------------------------------
module infix_expression_evaluator import iee_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out,
    iee_cfg_if.sink   i_cfg
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    // precedence mode register; the user must write it only while idle, the block itself does not enforce this
    logic r_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mode <= i_cfg.precedence_mode;
        end
    end

    // front -> queue
    logic     w_push;
    t_item    w_push_item;
    logic     w_q_full;
    // queue -> back
    logic     w_q_valid;
    logic     w_q_pop;
    t_item    w_q_item;
    // back <-> multiplier
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;
    // back status
    t_state   w_state;
    logic [LW-1:0] w_level;
    logic [WORD_W-1:0] w_value;

    iee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_char_code (i_in.char_code),
        .i_last_char (i_in.last_char),
        .o_push      (w_push),
        .o_item      (w_push_item),
        .i_full      (w_q_full)
    );

    iee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    iee_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    iee_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (r_mode),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_mul_req       (w_mul_req),
        .i_mul_rsp       (w_mul_rsp),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_out_value     (w_value),
        .o_out_malformed (o_out.malformed),
        .o_state         (w_state),
        .o_level         (w_level)
    );

    assign o_out.value = $signed(w_value);

`ifndef ASSERT_OFF
    // the multiplier is never restarted while a product is in flight
    a_mul_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |-> !w_mul_rsp.busy)
        else $error("multiply started while busy");

    // nesting never goes past the stack
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LW'(STACK_DEPTH))
        else $error("nesting level beyond stack depth");

    // a new result appears only out of the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_state == S_EMIT))
        else $error("result shown outside emit step");

    // queue pop only of a present item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid && w_state == S_FETCH)
        else $error("queue popped while empty");
`endif

endmodule

FILE: tb/infix_expression_evaluator_checker.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_checker
// Watches the character, result and config channels of the evaluator, keeps
// its own evaluation of each expression and compares every result word.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_checker import iee_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iee_in_if    i_in_mon,
    iee_out_if   i_out_mon,
    iee_cfg_if   i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending_count,
    output int   o_result_count,
    output int   o_malformed_count
);

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              malformed;
    } t_expected;

    t_expected         expected_results[$];

    // evaluation state of the open level and the saved outer levels
    logic              prec_mode;
    logic [WORD_W-1:0] lvl_product;
    logic [WORD_W-1:0] lvl_term;
    logic              lvl_op;
    t_frame            saved_levels[STACK_DEPTH];
    int                nest_depth;
    logic              error_seen;

    int                fails;
    int                results;
    int                malformed_seen;

    function void clear_expression();
        lvl_product = WORD_W'(1);
        lvl_term    = '0;
        lvl_op      = OP_ADD;
        nest_depth  = 0;
        error_seen  = 1'b0;
    endfunction

    function void take_operand(input logic [WORD_W-1:0] v);
        if (lvl_op == OP_MUL) begin
            lvl_term = lvl_term * v;
        end else begin
            lvl_term = lvl_term + v;
        end
    endfunction

    function void eval_char(input logic [7:0] c);
        logic [WORD_W-1:0] inner;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            take_operand(WORD_W'(c - CH_ZERO));
        end else if (c == CH_PLUS) begin
            lvl_op = OP_ADD;
        end else if (c == CH_STAR) begin
            if (prec_mode) begin
                // addition first: fold the finished sum into the product
                lvl_product = lvl_product * lvl_term;
                lvl_term    = '0;
                lvl_op      = OP_ADD;
            end else begin
                lvl_op = OP_MUL;
            end
        end else if (c == CH_OPEN) begin
            if (nest_depth >= STACK_DEPTH) begin
                error_seen = 1'b1;
            end else begin
                saved_levels[nest_depth] = '{product: lvl_product, term: lvl_term,
                                             op: lvl_op};
                nest_depth++;
                lvl_product = WORD_W'(1);
                lvl_term    = '0;
                lvl_op      = OP_ADD;
            end
        end else if (c == CH_CLOSE) begin
            if (nest_depth == 0) begin
                error_seen = 1'b1;
            end else begin
                inner = lvl_product * lvl_term;
                nest_depth--;
                lvl_product = saved_levels[nest_depth].product;
                lvl_term    = saved_levels[nest_depth].term;
                lvl_op      = saved_levels[nest_depth].op;
                take_operand(inner);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_expected want;
        if (!i_rst_n) begin
            prec_mode = 1'b0;
            clear_expression();
            expected_results.delete();
            fails          = 0;
            results        = 0;
            malformed_seen = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                prec_mode = i_cfg_mon.precedence_mode;
            end

            // results first: a word leaving now was predicted on an earlier edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                results++;
                if (i_out_mon.malformed) begin
                    malformed_seen++;
                end
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: value %0d malformed %0b",
                           i_out_mon.value, i_out_mon.malformed);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_mon.value !== want.value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), i_out_mon.value);
                        fails++;
                    end
                    if (i_out_mon.malformed !== want.malformed) begin
                        $error("malformed: expected %0b, actual %0b",
                               want.malformed, i_out_mon.malformed);
                        fails++;
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                eval_char(i_in_mon.char_code);
                if (i_in_mon.last_char) begin
                    want.value     = lvl_product * lvl_term;
                    want.malformed = error_seen || (nest_depth != 0);
                    expected_results.insert(expected_results.size(), want);
                    clear_expression();
                end
            end
        end
        o_fail_count      <= fails;
        o_pending_count   <= expected_results.size();
        o_result_count    <= results;
        o_malformed_count <= malformed_seen;
    end

endmodule

FILE: tb/infix_expression_evaluator_test.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_test
// Drives character words into the evaluator in both precedence modes, with
// random gaps and stalls on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_test import iee_pkg::*; ();

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 5;
    localparam int STACK_DEPTH     = 16;
    localparam int MAX_GAP         = 13;
    // queue plus front register can hold five characters, so this settle
    // time covers anything still in flight
    localparam int SETTLE_CYCLES   = 120;
    localparam int LONG_HOLD       = 300;
    localparam int PHASE_CHARS     = 232;
    localparam int WATCHDOG_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iee_in_if  in_ch ();
    iee_out_if out_ch ();
    iee_cfg_if cfg_ch ();

    int fail_count;
    int pending_count;
    int result_count;
    int malformed_count;

    // sender side
    logic [7:0] expr_chars[$];
    int         chars_sent;
    bit         tx_quiet;

    // receiver side; hold_request is written by the main sequence and run_phase, hold_taken only by the result side
    logic       rx_quiet;
    logic       hold_request;
    bit         hold_taken;
    int         rx_stall;
    int         rx_hold_left;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    infix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    infix_expression_evaluator_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_mon          (in_ch),
        .i_out_mon         (out_ch),
        .i_cfg_mon         (cfg_ch),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count),
        .o_result_count    (result_count),
        .o_malformed_count (malformed_count)
    );

    // ------------------------------------------------------------------------
    // result side: after each taken word, stall for a random gap up to MAX_GAP;
    // one long hold-off on request so the input queue fills and backs up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall     = 0;
            rx_hold_left = 0;
            hold_taken   = 1'b0;
        end else begin
            if (hold_request && !hold_taken) begin
                hold_taken   = 1'b1;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                rx_stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
                out_ch.ready <= (rx_stall == 0);
            end else if (rx_stall != 0) begin
                rx_stall--;
                out_ch.ready <= (rx_stall == 0);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // character side
    // ------------------------------------------------------------------------

    // one word: random gap with valid low, then hold until taken; valid is
    // left high so a zero-gap follower goes out back to back
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        in_ch.last_char <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // sender pauses until every predicted result has come out, then lets
    // the back end settle (a trailing non-last char may still be in flight)
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        // pending count is registered in the checker, so it lags the handshake
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode register is only touched with the evaluator idle
    task automatic write_mode(input logic mode);
        wait_for_results();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.precedence_mode <= mode;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_op();
        return ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_STAR;
    endfunction

    // filler, mostly blanks the evaluator ignores, now and then any byte
    function automatic logic [7:0] noise_char();
        return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h20;
    endfunction

    // appends one character to the expression under construction
    function automatic void add_char(input logic [7:0] c);
        expr_chars.insert(expr_chars.size(), c);
    endfunction

    // fills expr_chars with one expression; most are well formed
    function automatic void build_expression();
        int  shape;
        int  n;
        int  open;
        int  k;
        int  pick;
        bit  want_operand;
        expr_chars.delete();
        shape = $urandom_range(0, 9);
        if (shape < 7) begin
            // well formed apart from the odd filler byte, shallow nesting, some filler
            open         = 0;
            want_operand = 1'b1;
            n            = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_char(noise_char());
                end
                if (want_operand) begin
                    if ($urandom_range(0, 3) == 0 && open < 4) begin
                        add_char(CH_OPEN);
                        open++;
                    end else begin
                        add_char(random_digit());
                        want_operand = 1'b0;
                    end
                end else if ($urandom_range(0, 3) == 0 && open > 0) begin
                    add_char(CH_CLOSE);
                    open--;
                end else begin
                    add_char(random_op());
                    want_operand = 1'b1;
                end
            end
            if (want_operand) begin
                add_char(random_digit());
            end
            while (open > 0) begin
                add_char(CH_CLOSE);
                open--;
            end
        end else if (shape == 7) begin
            // long product chain of large digits: can drive the value past 2^63
            n = $urandom_range(10, 26);
            for (int i = 0; i < n; i++) begin
                add_char(CH_ZERO + 8'($urandom_range(5, 9)));
                if (i != n - 1) begin
                    add_char(($urandom_range(0, 3) == 0) ? CH_PLUS : CH_STAR);
                end
            end
        end else if (shape == 8) begin
            // deep nesting around the stack limit, closes may not match
            k = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_char(random_digit());
                    add_char(random_op());
                end
                add_char(CH_OPEN);
            end
            add_char(random_digit());
            n = $urandom_range(k - 3, k + 2);
            for (int i = 0; i < n; i++) begin
                add_char(CH_CLOSE);
            end
        end else begin
            // broken: random mix of tokens and raw bytes
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0: add_char(random_digit());
                    1: add_char(CH_PLUS);
                    2: add_char(CH_STAR);
                    3: add_char(CH_OPEN);
                    4: add_char(CH_CLOSE);
                    default: add_char(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endfunction

    task automatic send_expression();
        build_expression();
        for (int i = 0; i < expr_chars.size(); i++) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    // random expressions until about target chars have gone in; optional
    // long receiver hold-off and a full sender pause part way through
    task automatic run_phase(input int target, input bit with_hold, input bit with_pause);
        int  first;
        bit  paused;
        first  = chars_sent;
        paused = 1'b0;
        while (chars_sent - first < target) begin
            // roughly one expression in five is sent with no gaps; independently, one in five sees no receiver stalls
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);
            if (with_hold && chars_sent - first >= 40) begin
                hold_request <= 1'b1;
            end
            if (with_pause && !paused && chars_sent - first >= target / 2) begin
                paused = 1'b1;
                wait_for_results();
            end
            send_expression();
        end
        tx_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid            <= 1'b0;
        in_ch.char_code        <= '0;
        in_ch.last_char        <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.precedence_mode <= 1'b0;
        rx_quiet               <= 1'b0;
        hold_request           <= 1'b0;
        i_rst_n                <= 1'b0;
        chars_sent             = 0;
        tx_quiet               = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, equal precedence
        write_mode(1'b0);
        send_text("7");          // lone number
        send_text(" ");          // empty expression
        send_text("()");         // empty group
        send_text("+3");         // leading operator
        send_text("23");         // operands with no operator between
        send_text(")5");         // close without open
        send_text("(4");         // group left open
        send_text("2+3*(4)");    // both operators and a group
        send_char(8'hFF, 1'b0);  // top code, ignored
        send_char(CH_NINE, 1'b1);
        send_char(8'h00, 1'b0);  // bottom code, ignored
        send_char(CH_ZERO, 1'b1);

        // random, alternating modes
        write_mode(1'b1);
        run_phase(PHASE_CHARS, 1'b1, 1'b0);
        write_mode(1'b0);
        run_phase(PHASE_CHARS, 1'b0, 1'b1);
        write_mode(1'b1);
        run_phase(PHASE_CHARS, 1'b0, 1'b0);
        write_mode(1'b0);
        run_phase(PHASE_CHARS, 1'b0, 1'b0);

        wait_for_results();
        if (pending_count != 0) begin
            $error("%0d expected results never came out", pending_count);
        end

        $display("run covered %0d characters in both precedence modes, nesting past %0d",
                 chars_sent, STACK_DEPTH);
        $display("%0d result words checked, %0d of them flagged malformed",
                 result_count, malformed_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard stop if the evaluator hangs
    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("timeout after %0d cycles", WATCHDOG_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: infix_expression_evaluator.f
rtl/iee_pkg.sv
rtl/iee_if.sv
rtl/iee_front.sv
rtl/iee_queue.sv
rtl/iee_mul.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
tb/infix_expression_evaluator_checker.sv
tb/infix_expression_evaluator_test.sv
